[rtl/grc_pkg.sv]
// grc_pkg: shared types, constants and helper functions of the grid ray caster.
// No dependencies; every other rtl file imports it.
`timescale 1ns / 1ps
`default_nettype none

package grc_pkg;

    localparam int GRID_COLS_DEF  = 32;
    localparam int GRID_ROWS_DEF  = 16;
    localparam int TILE_SHIFT_DEF = 6;

    localparam int MAP_DEPTH = 512;
    localparam int MAP_AW    = 9;
    localparam int CFG_W     = 19;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam int CORDIC_STEPS = 14;
    localparam int DIV_BITS     = 32;
    localparam int ROOT_BITS    = 20;

    localparam logic signed [17:0] CORDIC_GAIN = 18'sd9949;
    localparam logic [24:0]        SLOPE_MAX   = 25'h1000000;
    localparam logic [19:0]        NO_HIT_DIST = 20'hFFFFF;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CAST  = 1'b1;

    localparam logic [1:0] CFG_VIEWER_X     = 2'd0;
    localparam logic [1:0] CFG_VIEWER_Y     = 2'd1;
    localparam logic [1:0] CFG_WORLD_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_WORLD_HEIGHT = 2'd3;

    typedef struct packed {
        logic        func;
        logic [8:0]  cell_index;
        logic [3:0]  cell_value;
        logic [15:0] ray_angle;
        logic [9:0]  strip_index;
    } t_in_item;

    typedef struct packed {
        logic [19:0] hit_distance;
        logic [18:0] hit_x;
        logic [18:0] hit_y;
        logic [3:0]  wall_code;
        logic        hit_vertical;
        logic        facing_down;
        logic        facing_right;
        logic        no_hit;
        logic [9:0]  strip_out;
    } t_out_item;

    typedef struct packed {
        logic [18:0] viewer_x;
        logic [18:0] viewer_y;
        logic [10:0] world_width;
        logic [10:0] world_height;
    } t_cfg;

    // classified command, as held in the queue between front and back
    typedef struct packed {
        logic               is_cast;
        logic [8:0]         cell_index;
        logic [3:0]         cell_value;
        logic [9:0]         strip;
        logic               down;
        logic               right;
        logic               flip;
        logic signed [17:0] z0;
    } t_cmd;

    typedef struct packed {
        logic clearing;
        logic take;
    } t_back_stat;

    typedef enum logic [3:0] {
        B_CLEAR, B_IDLE, B_CORD, B_DIV, B_PREP, B_START,
        B_WCHK, B_WRD, B_SQX, B_SQY, B_SQRT, B_OUT
    } t_bstate;

    // arctangent of 2^-i in units of 1/65536 turn
    function automatic logic signed [17:0] atan_turn(input logic [3:0] i);
        logic signed [17:0] a;
        case (i)
            4'd0:    a = 18'sd8192;
            4'd1:    a = 18'sd4836;
            4'd2:    a = 18'sd2555;
            4'd3:    a = 18'sd1297;
            4'd4:    a = 18'sd651;
            4'd5:    a = 18'sd326;
            4'd6:    a = 18'sd163;
            4'd7:    a = 18'sd81;
            4'd8:    a = 18'sd41;
            4'd9:    a = 18'sd20;
            4'd10:   a = 18'sd10;
            4'd11:   a = 18'sd5;
            4'd12:   a = 18'sd3;
            4'd13:   a = 18'sd1;
            default: a = 18'sd0;
        endcase
        return a;
    endfunction

    // arithmetic shift that truncates toward zero
    function automatic logic signed [17:0] shr0(input logic signed [17:0] v,
                                                 input logic [3:0] s);
        logic [17:0] mag;
        mag = v[17] ? 18'(-v) : 18'(v);
        mag = mag >> s;
        return v[17] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

`default_nettype wire

[rtl/grid_ray_caster.sv]
// grid_ray_caster: top level; configuration registers, front (classify and queue)
// and back (ray walk) halves. Depends on grc_pkg, grc_front, grc_back.
//
// Casts one ray over a tile grid from the configured viewer position. Beats
// enter through push/full and results leave through empty/pop; func 0 writes
// one 4-bit wall code into the 512-cell map and gives no result, func 1 casts
// a ray and gives exactly one result. After reset the map is cleared one cell
// per cycle, during which full stays high; config writes are taken as usual.
// A cast runs the CORDIC, then the two slope divisions (one shared radix-2
// divider, one quotient bit per cycle), then the two walks, each with a prep
// and a start step and then a probe and a map read per grid line crossed,
// then the two distance roots. A four-beat queue between front and back
// keeps accepting beats while a cast runs, and the result register lets the
// next cast run while a result waits to be popped. The user must write
// config only while the block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module grid_ray_caster #(
    parameter int GRID_COLS  = grc_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS  = grc_pkg::GRID_ROWS_DEF,
    parameter int TILE_SHIFT = grc_pkg::TILE_SHIFT_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  grc_pkg::t_in_item        i_item,
    output logic                     empty,
    input  logic                     pop,
    output grc_pkg::t_out_item       o_result,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [grc_pkg::CFG_W-1:0] i_cfg_data
);
    import grc_pkg::*;

    t_cfg       r_cfg;
    t_back_stat stat;
    logic       cmd_valid;
    t_cmd       cmd;

    // config registers, one beat per write, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.viewer_x     <= '0;
            r_cfg.viewer_y     <= '0;
            r_cfg.world_width  <= 11'd1280;
            r_cfg.world_height <= 11'd832;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VIEWER_X:     r_cfg.viewer_x     <= i_cfg_data;
                CFG_VIEWER_Y:     r_cfg.viewer_y     <= i_cfg_data;
                CFG_WORLD_WIDTH:  r_cfg.world_width  <= i_cfg_data[10:0];
                CFG_WORLD_HEIGHT: r_cfg.world_height <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // front: quadrant fold and facing flags, then the command queue
    grc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .i_stat      (stat),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // back: map store, trig, slopes, two grid walks, distances, result register
    grc_back #(
        .GRID_COLS  (GRID_COLS),
        .GRID_ROWS  (GRID_ROWS),
        .TILE_SHIFT (TILE_SHIFT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

[rtl/grc_front.sv]
// grc_front: accepts input beats, classifies them and queues them for the back end.
// Depends on grc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module grc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  grc_pkg::t_in_item     i_item,
    input  grc_pkg::t_back_stat   i_stat,
    output logic                  o_cmd_valid,
    output grc_pkg::t_cmd         o_cmd
);
    import grc_pkg::*;

    t_cmd             r_q [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_count;
    logic [QAW-1:0]   n_wp, n_rp;
    logic [QAW:0]     n_count;
    logic             wr, rd;
    t_cmd             cmd_in;
    logic [15:0]      ang;

    // quadrant fold for the CORDIC and the facing flags
    always_comb begin
        ang               = i_item.ray_angle;
        cmd_in.is_cast    = (i_item.func == FUNC_CAST);
        cmd_in.cell_index = i_item.cell_index;
        cmd_in.cell_value = i_item.cell_value;
        cmd_in.strip      = i_item.strip_index;
        cmd_in.down       = (ang != 16'd0) && (ang < 16'd32768);
        cmd_in.right      = (ang < 16'd16384) || (ang > 16'd49152);
        if (ang >= 16'd16384 && ang < 16'd49152) begin
            cmd_in.z0   = $signed({2'b00, ang}) - 18'sd32768;
            cmd_in.flip = 1'b1;
        end else if (ang < 16'd16384) begin
            cmd_in.z0   = $signed({2'b00, ang});
            cmd_in.flip = 1'b0;
        end else begin
            cmd_in.z0   = $signed({2'b00, ang}) - 18'sd65536;
            cmd_in.flip = 1'b0;
        end
    end

    assign full        = (r_count == (QAW+1)'(QDEPTH)) || i_stat.clearing;
    assign wr          = push && !full;
    assign rd          = i_stat.take;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_wp    = wr ? r_wp + 1'b1 : r_wp;
        n_rp    = rd ? r_rp + 1'b1 : r_rp;
        n_count = r_count;
        if (wr && !rd) begin
            n_count = r_count + 1'b1;
        end else if (rd && !wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("queue count beyond depth");

    a_count_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(wr) && !$past(rd)) |-> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not follow a write");

endmodule

`default_nettype wire

[rtl/grc_back.sv]
// grc_back: map store, CORDIC, slope divider, grid walk, distance root and result register.
// Depends on grc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module grc_back #(
    parameter int GRID_COLS  = grc_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS  = grc_pkg::GRID_ROWS_DEF,
    parameter int TILE_SHIFT = grc_pkg::TILE_SHIFT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  grc_pkg::t_cfg         i_cfg,
    input  logic                  i_cmd_valid,
    input  grc_pkg::t_cmd         i_cmd,
    output grc_pkg::t_back_stat   o_stat,
    output logic                  empty,
    input  logic                  pop,
    output grc_pkg::t_out_item    o_result
);
    import grc_pkg::*;

    localparam int SH      = TILE_SHIFT + 8;
    localparam int STEP_SH = 8 - TILE_SHIFT;
    localparam logic [18:0]        FLOOR_MASK = ~19'((1 << SH) - 1);
    localparam logic [19:0]        TILE20     = 20'(1 << SH);
    localparam logic signed [26:0] TILE27     = 27'(1 << SH);

    // map store and its read port
    logic [3:0]        r_map [MAP_DEPTH];
    logic [3:0]        r_mrd;
    logic              mem_we;
    logic [MAP_AW-1:0] mem_wa, mem_ra;
    logic [3:0]        mem_wd;

    t_bstate r_state, n_state;
    logic [5:0]        r_cnt, n_cnt;
    logic [MAP_AW-1:0] r_clr, n_clr;
    t_cmd              r_cmd, n_cmd;
    logic signed [17:0] r_cx, r_cy, r_z, n_cx, n_cy, n_z;
    logic [15:0]       r_sa, r_ca, r_den, n_sa, n_ca, n_den;
    logic              r_dsel, n_dsel;
    logic [31:0]       r_dvd, r_quo, n_dvd, n_quo;
    logic [16:0]       r_rem, n_rem;
    logic [24:0]       r_tn, r_ct, n_tn, n_ct;
    logic              r_pass, n_pass;
    logic [41:0]       r_prod, n_prod;
    logic [19:0]       r_fix, n_fix;
    logic signed [26:0] r_wx, r_wy, r_sx, r_sy, n_wx, n_wy, n_sx, n_sy;
    logic              r_hf, r_vf, n_hf, n_vf;
    logic [18:0]       r_hx, r_hy, r_vx, r_vy, n_hx, n_hy, n_vx, n_vy;
    logic [3:0]        r_hc, r_vc, n_hc, n_vc;
    logic [39:0]       r_acc, r_sv, r_sr, r_sb, n_acc, n_sv, n_sr, n_sb;
    logic [19:0]       r_hd, r_vd, n_hd, n_vd;
    logic              r_out_valid;
    t_out_item         r_out;

    // datapath terms
    logic [3:0]         i4;
    logic signed [17:0] nx, ny, sv, cv;
    logic [17:0]        s_abs, c_abs;
    logic [16:0]        rem_sh;
    logic               ge;
    logic [31:0]        q_full;
    logic [24:0]        slope_q;
    logic [19:0]        fix, len_w;
    logic signed [26:0] off, stepc, stept, wq, hq, vx27, vy27, cx, cy, prx, pry;
    logic               in_world, p_out, g_out, i_out;
    logic [18:0]        col, row, hpx, hpy, ax, ay;
    logic [12:0]        idx;
    logic [39:0]        sq_t, sr_next, sv_next;
    logic [19:0]        hd_eff, vd_eff;
    logic               use_v;
    t_out_item          res;
    logic               take, out_load, rec, rec_f;
    logic [3:0]         rec_c;

    always_comb begin
        i4 = r_cnt[3:0];
        if (!r_z[17]) begin
            nx = r_cx - shr0(r_cy, i4);
            ny = r_cy + shr0(r_cx, i4);
        end else begin
            nx = r_cx + shr0(r_cy, i4);
            ny = r_cy - shr0(r_cx, i4);
        end
        sv    = r_cmd.flip ? -ny : ny;
        cv    = r_cmd.flip ? -nx : nx;
        s_abs = sv[17] ? 18'(-sv) : 18'(sv);
        c_abs = cv[17] ? 18'(-cv) : 18'(cv);

        rem_sh  = {r_rem[15:0], r_dvd[31]};
        ge      = rem_sh >= {1'b0, r_den};
        q_full  = {r_quo[30:0], ge};
        slope_q = (r_den == '0 || q_full > {7'b0, SLOPE_MAX}) ? SLOPE_MAX : q_full[24:0];

        vx27 = $signed({8'b0, i_cfg.viewer_x});
        vy27 = $signed({8'b0, i_cfg.viewer_y});
        if (!r_pass) begin
            fix   = {1'b0, i_cfg.viewer_y & FLOOR_MASK} + (r_cmd.down ? TILE20 : 20'd0);
            len_w = r_cmd.down ? fix - {1'b0, i_cfg.viewer_y} : {1'b0, i_cfg.viewer_y} - fix;
        end else begin
            fix   = {1'b0, i_cfg.viewer_x & FLOOR_MASK} + (r_cmd.right ? TILE20 : 20'd0);
            len_w = r_cmd.right ? fix - {1'b0, i_cfg.viewer_x} : {1'b0, i_cfg.viewer_x} - fix;
        end
        off   = $signed({1'b0, r_prod[41:16]});
        stepc = $signed({2'b0, r_ct} >> STEP_SH);
        stept = $signed({2'b0, r_tn} >> STEP_SH);

        // probe point, one pixel back when walking up or left
        wq  = $signed({8'b0, i_cfg.world_width, 8'b0});
        hq  = $signed({8'b0, i_cfg.world_height, 8'b0});
        cx  = (r_pass && !r_cmd.right) ? -27'sd256 : 27'sd0;
        cy  = (!r_pass && !r_cmd.down) ? -27'sd256 : 27'sd0;
        prx = r_wx + cx;
        pry = r_wy + cy;
        in_world = !r_wx[26] && (r_wx <= wq) && !r_wy[26] && (r_wy <= hq);
        p_out    = prx[26] || (prx > wq) || pry[26] || (pry > hq);
        col      = prx[18:0] >> SH;
        row      = pry[18:0] >> SH;
        g_out    = (col >= 19'(GRID_COLS)) || (row >= 19'(GRID_ROWS));
        idx      = 13'(row[6:0]) * 13'(GRID_COLS) + 13'(col[6:0]);
        i_out    = idx >= 13'(MAP_DEPTH);

        hpx = r_pass ? r_vx : r_hx;
        hpy = r_pass ? r_vy : r_hy;
        ax  = (hpx >= i_cfg.viewer_x) ? hpx - i_cfg.viewer_x : i_cfg.viewer_x - hpx;
        ay  = (hpy >= i_cfg.viewer_y) ? hpy - i_cfg.viewer_y : i_cfg.viewer_y - hpy;

        sq_t = r_sr + r_sb;
        if (r_sv >= sq_t) begin
            sv_next = r_sv - sq_t;
            sr_next = (r_sr >> 1) + r_sb;
        end else begin
            sv_next = r_sv;
            sr_next = r_sr >> 1;
        end

        hd_eff = r_hf ? r_hd : NO_HIT_DIST;
        vd_eff = r_vf ? r_vd : NO_HIT_DIST;
        use_v  = vd_eff < hd_eff;
        res.facing_down  = r_cmd.down;
        res.facing_right = r_cmd.right;
        res.no_hit       = !r_hf && !r_vf;
        res.strip_out    = r_cmd.strip;
        if (!r_hf && !r_vf) begin
            res.hit_distance = NO_HIT_DIST;
            res.hit_x        = '0;
            res.hit_y        = '0;
            res.wall_code    = '0;
            res.hit_vertical = 1'b0;
        end else if (use_v) begin
            res.hit_distance = r_vd;
            res.hit_x        = r_vx;
            res.hit_y        = r_vy;
            res.wall_code    = r_vc;
            res.hit_vertical = 1'b1;
        end else begin
            res.hit_distance = r_hd;
            res.hit_x        = r_hx;
            res.hit_y        = r_hy;
            res.wall_code    = r_hc;
            res.hit_vertical = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;  n_cnt = r_cnt;   n_clr = r_clr;   n_cmd = r_cmd;
        n_cx = r_cx;  n_cy = r_cy;  n_z = r_z;
        n_sa = r_sa;  n_ca = r_ca;  n_den = r_den;  n_dsel = r_dsel;
        n_dvd = r_dvd;  n_quo = r_quo;  n_rem = r_rem;  n_tn = r_tn;  n_ct = r_ct;
        n_pass = r_pass;  n_prod = r_prod;  n_fix = r_fix;
        n_wx = r_wx;  n_wy = r_wy;  n_sx = r_sx;  n_sy = r_sy;
        n_hf = r_hf;  n_vf = r_vf;  n_hx = r_hx;  n_hy = r_hy;  n_vx = r_vx;  n_vy = r_vy;
        n_hc = r_hc;  n_vc = r_vc;
        n_acc = r_acc;  n_sv = r_sv;  n_sr = r_sr;  n_sb = r_sb;  n_hd = r_hd;  n_vd = r_vd;
        mem_we = 1'b0;  mem_wa = r_clr;  mem_wd = '0;  mem_ra = idx[MAP_AW-1:0];
        take = 1'b0;  out_load = 1'b0;
        rec = 1'b0;  rec_f = 1'b0;  rec_c = '0;

        case (r_state)
            B_CLEAR: begin
                mem_we = 1'b1;
                n_clr  = r_clr + 1'b1;
                if (r_clr == MAP_AW'(MAP_DEPTH - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_cmd_valid) begin
                    take  = 1'b1;
                    n_cmd = i_cmd;
                    if (!i_cmd.is_cast) begin
                        mem_we = 1'b1;
                        mem_wa = i_cmd.cell_index;
                        mem_wd = i_cmd.cell_value;
                    end else begin
                        n_cx    = CORDIC_GAIN;
                        n_cy    = '0;
                        n_z     = i_cmd.z0;
                        n_cnt   = '0;
                        n_state = B_CORD;
                    end
                end
            end
            B_CORD: begin
                n_cx  = nx;
                n_cy  = ny;
                n_z   = r_z[17] ? r_z + atan_turn(i4) : r_z - atan_turn(i4);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'(CORDIC_STEPS - 1)) begin
                    n_sa    = s_abs[15:0];
                    n_ca    = c_abs[15:0];
                    n_dsel  = 1'b0;
                    n_den   = c_abs[15:0];
                    n_dvd   = {s_abs[15:0], 16'b0};
                    n_rem   = '0;
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_state = B_DIV;
                end
            end
            B_DIV: begin
                n_rem = ge ? rem_sh - {1'b0, r_den} : rem_sh;
                n_quo = q_full;
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'(DIV_BITS - 1)) begin
                    n_cnt = '0;
                    n_rem = '0;
                    n_quo = '0;
                    if (!r_dsel) begin
                        n_tn   = slope_q;
                        n_dsel = 1'b1;
                        n_den  = r_sa;
                        n_dvd  = {r_ca, 16'b0};
                    end else begin
                        n_ct    = slope_q;
                        n_pass  = 1'b0;
                        n_state = B_PREP;
                    end
                end
            end
            B_PREP: begin
                n_fix   = fix;
                n_prod  = {25'b0, len_w[16:0]} * {17'b0, (r_pass ? r_tn : r_ct)};
                n_state = B_START;
            end
            B_START: begin
                if (!r_pass) begin
                    n_wy = $signed({7'b0, r_fix});
                    n_wx = r_cmd.right ? vx27 + off : vx27 - off;
                    n_sx = r_cmd.right ? stepc : -stepc;
                    n_sy = r_cmd.down ? TILE27 : -TILE27;
                end else begin
                    n_wx = $signed({7'b0, r_fix});
                    n_wy = r_cmd.down ? vy27 + off : vy27 - off;
                    n_sx = r_cmd.right ? TILE27 : -TILE27;
                    n_sy = r_cmd.down ? stept : -stept;
                end
                n_state = B_WCHK;
            end
            B_WCHK: begin
                if (!in_world) begin
                    rec = 1'b1;
                end else if (p_out || g_out || i_out) begin
                    rec   = 1'b1;
                    rec_f = 1'b1;
                end else begin
                    n_state = B_WRD;
                end
            end
            B_WRD: begin
                if (r_mrd != 4'd0) begin
                    rec   = 1'b1;
                    rec_f = 1'b1;
                    rec_c = r_mrd;
                end else begin
                    n_wx    = r_wx + r_sx;
                    n_wy    = r_wy + r_sy;
                    n_state = B_WCHK;
                end
            end
            B_SQX: begin
                n_acc   = 40'(ax) * 40'(ax);
                n_state = B_SQY;
            end
            B_SQY: begin
                n_sv    = r_acc + 40'(ay) * 40'(ay);
                n_sr    = '0;
                n_sb    = 40'h1 << 38;
                n_cnt   = '0;
                n_state = B_SQRT;
            end
            B_SQRT: begin
                n_sv  = sv_next;
                n_sr  = sr_next;
                n_sb  = r_sb >> 2;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'(ROOT_BITS - 1)) begin
                    if (!r_pass) begin
                        n_hd    = sr_next[19:0];
                        n_pass  = 1'b1;
                        n_state = B_SQX;
                    end else begin
                        n_vd    = sr_next[19:0];
                        n_state = B_OUT;
                    end
                end
            end
            B_OUT: begin
                if (!r_out_valid || pop) begin
                    out_load = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase

        // end of one walk pass
        if (rec) begin
            if (!r_pass) begin
                n_hf    = rec_f;
                n_hc    = rec_c;
                n_hx    = r_wx[18:0];
                n_hy    = r_wy[18:0];
                n_pass  = 1'b1;
                n_state = B_PREP;
            end else begin
                n_vf    = rec_f;
                n_vc    = rec_c;
                n_vx    = r_wx[18:0];
                n_vy    = r_wy[18:0];
                n_pass  = 1'b0;
                n_state = B_SQX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_wa] <= mem_wd;
        end
        r_mrd <= r_map[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_cnt       <= '0;
            r_clr       <= '0;
            r_pass      <= 1'b0;
            r_dsel      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_clr   <= n_clr;
            r_pass  <= n_pass;
            r_dsel  <= n_dsel;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;  r_cx <= n_cx;  r_cy <= n_cy;  r_z <= n_z;
        r_sa <= n_sa;  r_ca <= n_ca;  r_den <= n_den;
        r_dvd <= n_dvd;  r_quo <= n_quo;  r_rem <= n_rem;  r_tn <= n_tn;  r_ct <= n_ct;
        r_prod <= n_prod;  r_fix <= n_fix;
        r_wx <= n_wx;  r_wy <= n_wy;  r_sx <= n_sx;  r_sy <= n_sy;
        r_hf <= n_hf;  r_vf <= n_vf;  r_hx <= n_hx;  r_hy <= n_hy;
        r_vx <= n_vx;  r_vy <= n_vy;  r_hc <= n_hc;  r_vc <= n_vc;
        r_acc <= n_acc;  r_sv <= n_sv;  r_sr <= n_sr;  r_sb <= n_sb;
        r_hd <= n_hd;  r_vd <= n_vd;
        if (out_load) begin
            r_out <= res;
        end
    end

    assign o_stat.clearing = (r_state == B_CLEAR);
    assign o_stat.take     = take;
    assign empty           = !r_out_valid;
    assign o_result        = r_out;

    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR) |-> !o_stat.take)
        else $error("command taken during map clear");

    a_read_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_state == B_WRD) |-> $past(r_state) == B_WCHK)
        else $error("map read without a probe check");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> $past(r_state) == B_OUT)
        else $error("result loaded outside the output state");

endmodule

`default_nettype wire

[dv/grc_checker.sv]
// grc_checker: watches the beat, result and register ports of grid_ray_caster,
// predicts every cast result and compares it. Depends on grc_pkg.
`timescale 1ns / 1ps

module grc_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_full,
    input  grc_pkg::t_in_item     i_item,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  grc_pkg::t_out_item    i_result,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [18:0]           i_cfg_data,
    output int                    o_pending,
    output int                    o_errors,
    output int                    o_results
);
    import grc_pkg::*;

    localparam int COLS = 32;
    localparam int ROWS = 16;
    localparam int TSH  = 6;
    localparam longint TILE = longint'(1) << (TSH + 8);
    localparam longint unsigned SLOPE_CAP = 64'd1 << 24;

    logic [3:0] cells [MAP_DEPTH];
    t_cfg       cfg;
    t_out_item  cast_q [$];
    int         errors;
    int         results;

    function automatic int trunc_shr(input int v, input int s);
        return v >= 0 ? (v >>> s) : -((-v) >>> s);
    endfunction

    // 14-step CORDIC, Q1.14 sine and cosine of a turn fraction
    function automatic void sin_cos(input int ang, output int s, output int c);
        int x, y, z, nx, ny, a;
        bit flip;
        x = 9949;
        y = 0;
        flip = 0;
        if (ang >= 16384 && ang < 49152) begin
            z = ang - 32768;
            flip = 1;
        end else if (ang < 16384) begin
            z = ang;
        end else begin
            z = ang - 65536;
        end
        for (int i = 0; i < 14; i++) begin
            a = int'(atan_turn(4'(i)));
            if (z >= 0) begin
                nx = x - trunc_shr(y, i);
                ny = y + trunc_shr(x, i);
                z -= a;
            end else begin
                nx = x + trunc_shr(y, i);
                ny = y - trunc_shr(x, i);
                z += a;
            end
            x = nx;
            y = ny;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic longint unsigned slope(input int num, input int den);
        longint unsigned n, d, q;
        n = longint'(num < 0 ? -num : num);
        d = longint'(den < 0 ? -den : den);
        if (d == 0) return SLOPE_CAP;
        q = (n << 16) / d;
        return q > SLOPE_CAP ? SLOPE_CAP : q;
    endfunction

    function automatic longint offset(input longint unsigned len,
                                      input longint unsigned slp, input bit pos);
        longint m;
        m = longint'((len * slp) >> 16);
        return pos ? m : -m;
    endfunction

    // wall test of one probe point; out of world or grid is a wall of code 0
    function automatic bit is_wall(input longint x, input longint y, output int code);
        longint wq, hq, col, row;
        wq = longint'(cfg.world_width) << 8;
        hq = longint'(cfg.world_height) << 8;
        code = 0;
        if (x < 0 || x > wq || y < 0 || y > hq) return 1;
        col = x >>> (8 + TSH);
        row = y >>> (8 + TSH);
        if (col >= COLS || row >= ROWS) return 1;
        if (row * COLS + col >= MAP_DEPTH) return 1;
        code = cells[row * COLS + col];
        return code != 0;
    endfunction

    function automatic bit walk_lines(input longint x0, input longint y0,
                                      input longint sx, input longint sy,
                                      input longint cx, input longint cy,
                                      output longint hx, output longint hy,
                                      output int code);
        longint wq, hq, x, y;
        wq = longint'(cfg.world_width) << 8;
        hq = longint'(cfg.world_height) << 8;
        x = x0;
        y = y0;
        hx = 0;
        hy = 0;
        while (x >= 0 && x <= wq && y >= 0 && y <= hq) begin
            if (is_wall(x + cx, y + cy, code)) begin
                hx = x;
                hy = y;
                return 1;
            end
            x += sx;
            y += sy;
        end
        code = 0;
        return 0;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned hit_range(input longint x, input longint y);
        longint dx, dy;
        longint unsigned ax, ay;
        dx = x - longint'(cfg.viewer_x);
        dy = y - longint'(cfg.viewer_y);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        return int_sqrt(ax * ax + ay * ay);
    endfunction

    function automatic t_out_item cast_ray(input t_in_item it);
        t_out_item r;
        int ang, s, c, hc, vc;
        bit down, right, hf, vf;
        longint unsigned tn, ct, hd, vd;
        longint px, py, xi, yi, hx, hy, vx, vy;
        ang = int'(it.ray_angle);
        down = ang > 0 && ang < 32768;
        right = ang < 16384 || ang > 49152;
        sin_cos(ang, s, c);
        tn = slope(s, c);
        ct = slope(c, s);
        px = longint'(cfg.viewer_x);
        py = longint'(cfg.viewer_y);
        // horizontal grid lines first
        yi = (py >>> (TSH + 8)) << (TSH + 8);
        if (down) yi += TILE;
        xi = px + offset(yi > py ? yi - py : py - yi, ct, right);
        hf = walk_lines(xi, yi, offset(TILE, ct, right), down ? TILE : -TILE,
                        0, down ? 0 : -256, hx, hy, hc);
        // then vertical grid lines
        xi = (px >>> (TSH + 8)) << (TSH + 8);
        if (right) xi += TILE;
        yi = py + offset(xi > px ? xi - px : px - xi, tn, down);
        vf = walk_lines(xi, yi, right ? TILE : -TILE, offset(TILE, tn, down),
                        right ? 0 : -256, 0, vx, vy, vc);
        hd = hf ? hit_range(hx, hy) : 64'(NO_HIT_DIST);
        vd = vf ? hit_range(vx, vy) : 64'(NO_HIT_DIST);
        r = '0;
        if (!hf && !vf) begin
            r.hit_distance = NO_HIT_DIST;
        end else if (vd < hd) begin
            r.hit_distance = 20'(vd);
            r.hit_x = 19'(vx);
            r.hit_y = 19'(vy);
            r.wall_code = 4'(vc);
            r.hit_vertical = 1'b1;
        end else begin
            // tie goes to the horizontal hit
            r.hit_distance = 20'(hd);
            r.hit_x = 19'(hx);
            r.hit_y = 19'(hy);
            r.wall_code = 4'(hc);
        end
        r.facing_down = down;
        r.facing_right = right;
        r.no_hit = !hf && !vf;
        r.strip_out = it.strip_index;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (cells[k]) cells[k] = '0;
            cfg.viewer_x = '0;
            cfg.viewer_y = '0;
            cfg.world_width = 11'd1280;
            cfg.world_height = 11'd832;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VIEWER_X:     cfg.viewer_x = i_cfg_data;
                    CFG_VIEWER_Y:     cfg.viewer_y = i_cfg_data;
                    CFG_WORLD_WIDTH:  cfg.world_width = i_cfg_data[10:0];
                    CFG_WORLD_HEIGHT: cfg.world_height = i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                if (i_item.func == FUNC_WRITE) cells[i_item.cell_index] = i_item.cell_value;
                else cast_q.push_back(cast_ray(i_item));
            end
            if (i_pop && !i_empty) begin
                results++;
                if (cast_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("ERROR: unexpected result beat %p", i_result);
                end else begin
                    want = cast_q.pop_front();
                    if (want.hit_distance !== i_result.hit_distance ||
                        want.hit_x !== i_result.hit_x || want.hit_y !== i_result.hit_y ||
                        want.wall_code !== i_result.wall_code ||
                        want.hit_vertical !== i_result.hit_vertical ||
                        want.facing_down !== i_result.facing_down ||
                        want.facing_right !== i_result.facing_right ||
                        want.no_hit !== i_result.no_hit ||
                        want.strip_out !== i_result.strip_out) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("ERROR: result mismatch at %0t", $realtime);
                            $display("  expected %p", want);
                            $display("  actual   %p", i_result);
                        end
                    end
                end
            end
        end
        o_pending = cast_q.size();
        o_errors = errors;
        o_results = results;
    end

    initial begin
        errors = 0;
        results = 0;
        o_pending = 0;
        o_errors = 0;
        o_results = 0;
    end

endmodule

[dv/tb_top.sv]
// tb_top: stimulus and verdict for grid_ray_caster; grc_checker does the checking.
// Depends on grc_pkg, grid_ray_caster and grc_checker.
`timescale 1ns / 1ps

module tb_top;
    import grc_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 600;   // > worst cast plus queued map writes
    localparam int PER_PHASE   = 125;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    t_in_item   i_item = '0;
    logic       empty;
    logic       pop = 1'b0;
    t_out_item  o_result;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = CFG_VIEWER_X;
    logic [18:0] i_cfg_data = '0;

    int pending, errors, results;
    int cycles = 0;
    int send_idle = 0;      // percent of cycles the sender holds off
    int recv_stall = 0;     // percent of cycles the receiver stalls
    int n_casts = 0, n_writes = 0;

    always #5 i_clk = ~i_clk;

    grid_ray_caster dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    grc_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_full(full), .i_item(i_item),
        .i_empty(empty), .i_pop(pop), .i_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_pending(pending), .o_errors(errors), .o_results(results)
    );

    // receiver: one pop decision per falling edge
    always @(negedge i_clk) pop <= ($urandom_range(99) >= recv_stall);

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top failed");
            $finish;
        end
    end

    // one input beat; called at a falling edge, returns at a falling edge
    task automatic send_beat(input t_in_item it);
        if ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle);
        end
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        if (it.func == FUNC_CAST) n_casts++;
        else n_writes++;
    endtask

    task automatic cell_write(input int idx, input int val);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom});
        it.func = FUNC_WRITE;
        it.cell_index = 9'(idx);
        it.cell_value = 4'(val);
        send_beat(it);
    endtask

    task automatic ray(input int ang, input int strip);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom});
        it.func = FUNC_CAST;
        it.ray_angle = 16'(ang);
        it.strip_index = 10'(strip);
        send_beat(it);
    endtask

    // wait for every result, let trailing map writes retire, then stop
    task automatic drain;
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_view(input int vx, input int vy, input int w, input int h);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_VIEWER_X;
        i_cfg_data <= 19'(vx);
        @(negedge i_clk);
        i_cfg_idx <= CFG_VIEWER_Y;
        i_cfg_data <= 19'(vy);
        @(negedge i_clk);
        i_cfg_idx <= CFG_WORLD_WIDTH;
        i_cfg_data <= 19'(w);
        @(negedge i_clk);
        i_cfg_idx <= CFG_WORLD_HEIGHT;
        i_cfg_data <= 19'(h);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int w, h;
        t_in_item it;
        int angles [13] = '{0, 1, 8192, 16383, 16384, 16385, 32767, 32768,
                            32769, 49151, 49152, 49153, 65535};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int ph = 0; ph < 6; ph++) begin
            // sender/receiver idle mix rotates per phase
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 67; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 67; end
                default: begin send_idle = 38; recv_stall = 38; end
            endcase
            case (ph)
                0: set_view(640 * 256 + 128, 416 * 256 + 77, 1280, 832);
                1: begin
                    w = $urandom_range(2047, 64);
                    h = $urandom_range(2047, 64);
                    set_view($urandom_range(w * 256), $urandom_range(h * 256), w, h);
                end
                2: set_view(0, 0, 2047, 2047);
                3: set_view(524287, 524287, 0, 0);   // viewer outside a zero world
                4: set_view($urandom_range(524287), $urandom_range(524287),
                            $urandom_range(2047), $urandom_range(2047));
                default: set_view(1024 * 256, 512 * 256 + 255, 2047, 2047);
            endcase

            if (ph == 0) begin
                // corner cells, an extreme code and the boundary angles
                cell_write(0, 15);
                cell_write(511, 1);
                cell_write(33, 8);
                cell_write(13 * 32 + 12, 5);
                foreach (angles[k]) ray(angles[k], k == 0 ? 1023 : k);
                ray(40000, 0);
                cell_write(33, 0);           // clearing a cell back to empty
                ray(8192, 512);
            end

            for (int n = 0; n < PER_PHASE; n++) begin
                it = t_in_item'({$urandom, $urandom});
                it.func = ($urandom_range(99) < 35) ? FUNC_WRITE : FUNC_CAST;
                // sparse walls keep the walks long
                if (it.func == FUNC_WRITE && $urandom_range(99) < 50) it.cell_value = '0;
                send_beat(it);
            end
            // sender holds off until every result is back
            drain;
        end

        $display("covered %0d casts and %0d map writes over 6 register settings",
                 n_casts, n_writes);
        $display("%0d result beats checked, %0d mismatches", results, errors);
        if (errors == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
